// ===== hw/rtl/mh2_pkg.sv =====
// Package: shared constants, types and state encodings for the MurmurHash2 bucket selector.
`timescale 1ns / 1ps
`default_nettype none
package mh2_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'h6a5b223d;
	localparam logic [15:0] BUCKETS_RESET = 16'd1;

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 8'd1;

	localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL1,
		F_MUL2
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FIN,
		B_DIV,
		B_DONE
	} back_state_t;

	// One unfinalized key hash handed from the front to the back.
	typedef struct packed {
		logic        valid;
		logic [31:0] hash;
	} hash_push_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mh2_front.sv =====
// Front end: accepts key words and runs the per-word MurmurHash2 mix.
`timescale 1ns / 1ps
`default_nettype none
module mh2_front
	import mh2_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] key_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last_word,
	input  wire logic [15:0] total_length,
	input  wire logic [31:0] hash_seed,
	input  wire logic        q_full,
	output hash_push_t       push
);

	front_state_t state_q, state_d;

	logic [31:0] w_q;
	logic [2:0]  n_q;
	logic        last_q;
	logic [31:0] h_q;
	logic [31:0] k1_q;
	logic [31:0] hm_q;
	logic [31:0] run_q;
	logic        inside_q;

	logic        accept;
	logic        done;
	logic [2:0]  n_clamp;
	logic [31:0] tail_mask;
	logic [31:0] mul_in;
	logic [31:0] k_shr;
	logic [31:0] k2;
	logic [31:0] h_new;

	assign accept  = in_valid && !in_stall;
	assign n_clamp = (byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : byte_count;

	always_comb begin
		case (n_q)
			3'd3:    tail_mask = 32'h00ffffff;
			3'd2:    tail_mask = 32'h0000ffff;
			default: tail_mask = 32'h000000ff;
		endcase
	end

	assign mul_in = (n_q == FULL_WORD_BYTES) ? h_q : (h_q ^ (w_q & tail_mask));
	assign k_shr  = k1_q ^ (k1_q >> MIX_SHIFT);
	assign k2     = k_shr * MIX_MUL;

	always_comb begin
		if (n_q == FULL_WORD_BYTES) begin
			h_new = hm_q ^ k2;
		end else if (n_q == 3'd0) begin
			h_new = h_q;
		end else begin
			h_new = hm_q;
		end
	end

	// a last word waits here until the queue has room
	assign done = (state_q == F_MUL2) && !(last_q && q_full);

	always_comb begin
		push.valid = (state_q == F_MUL2) && last_q && !q_full;
		push.hash  = h_new;
		in_stall   = (state_q != F_IDLE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					state_d = F_MUL1;
				end
			end
			F_MUL1: state_d = F_MUL2;
			F_MUL2: begin
				if (done) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			run_q    <= 32'd0;
		end else if (done) begin
			inside_q <= !last_q;
			run_q    <= h_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q    <= key_word;
			n_q    <= n_clamp;
			last_q <= last_word;
			h_q    <= inside_q ? run_q : (hash_seed ^ {16'd0, total_length});
		end
		if (state_q == F_MUL1) begin
			k1_q <= w_q * MIX_MUL;
			hm_q <= mul_in * MIX_MUL;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mh2_queue.sv =====
// Two-entry queue of unfinalized key hashes between front and back.
`timescale 1ns / 1ps
`default_nettype none
module mh2_queue
	import mh2_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  hash_push_t       push,
	output logic             full,
	input  wire logic        pop,
	output logic             q_valid,
	output logic [31:0]      q_hash
);

	logic [31:0]       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_hash  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.hash;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mh2_back.sv =====
// Back end: finalization, hash magnitude and bit-serial remainder by the bucket count.
`timescale 1ns / 1ps
`default_nettype none
module mh2_back
	import mh2_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire logic [31:0] q_hash,
	output logic             pop,
	input  wire logic [15:0] divisor,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_value,
	output logic [15:0]      bucket
);

	back_state_t state_q, state_d;

	logic [31:0]          p_s1;
	logic [31:0]          hash_q;
	logic [31:0]          mag_q;
	logic [15:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic [31:0]          hash_out_q;
	logic [15:0]          bucket_q;

	logic [31:0] fin_pre;
	logic [31:0] fin_hash;
	logic [31:0] fin_mag;
	logic [16:0] rem_shift;
	logic [16:0] rem_sub;
	logic        load_out;
	logic        last_step;

	assign fin_pre   = q_hash ^ (q_hash >> FIN_SHIFT_A);
	assign fin_hash  = p_s1 ^ (p_s1 >> FIN_SHIFT_B);
	// the most negative hash negates to itself, which is its magnitude 2^31
	assign fin_mag   = fin_hash[31] ? (32'd0 - fin_hash) : fin_hash;
	assign rem_shift = {rem_q, mag_q[31]};
	assign rem_sub   = rem_shift - {1'b0, divisor};
	assign last_step = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign load_out  = (state_q == B_DONE) && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign hash_value = hash_out_q;
	assign bucket     = bucket_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = B_FIN;
				end
			end
			B_FIN: state_d = B_DIV;
			B_DIV: begin
				if (last_step) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (load_out) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			p_s1 <= fin_pre * MIX_MUL;
		end
		case (state_q)
			B_FIN: begin
				hash_q <= fin_hash;
				mag_q  <= fin_mag;
				rem_q  <= 16'd0;
				cnt_q  <= '0;
			end
			B_DIV: begin
				// one quotient bit per beat of the divider, MSB first
				mag_q <= {mag_q[30:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (rem_shift >= {1'b0, divisor}) begin
					rem_q <= rem_sub[15:0];
				end else begin
					rem_q <= rem_shift[15:0];
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			hash_out_q <= hash_q;
			bucket_q   <= rem_q;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/murmur2_hash_bucket_select_unit.sv =====
// Top level: MurmurHash2 bucket selector with configuration registers.
`timescale 1ns / 1ps
`default_nettype none
// Streams a key one 32-bit little-endian word per beat and, on the word marked last,
// returns the 32-bit MurmurHash2 of the key and its bucket, |hash as signed| modulo
// bucket_count (a count of zero acts as one). The front end takes a word, then steps
// through F_MUL1 and F_MUL2 for the two chained 32x32 multiplies of the word mix,
// with the running-hash multiply alongside, before it takes the next word. Finished
// key hashes wait in a two-entry queue. The back end registers the finalization
// multiply as it pops a hash, the magnitude in B_FIN, then runs a bit-serial remainder
// unit in B_DIV and loads the output register in B_DONE; short keys arriving faster
// than the back end drains them fill the queue and then stall the input.
module murmur2_hash_bucket_select_unit
	import mh2_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [31:0]          key_word,
	input  wire logic [2:0]           byte_count,
	input  wire logic                 last_word,
	input  wire logic [15:0]          total_length,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               hash_value,
	output logic [15:0]               bucket,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	logic [31:0] hash_seed_q;
	logic [15:0] bucket_count_q;
	logic [15:0] divisor;

	hash_push_t  push;
	logic        q_full;
	logic        q_valid;
	logic [31:0] q_hash;
	logic        pop;

	assign cfg_ready = 1'b1;
	assign divisor   = (bucket_count_q == 16'd0) ? 16'd1 : bucket_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q    <= SEED_RESET;
			bucket_count_q <= BUCKETS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HASH_SEED:    hash_seed_q    <= cfg_data;
				CFG_BUCKET_COUNT: bucket_count_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	mh2_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_word     (key_word),
		.byte_count   (byte_count),
		.last_word    (last_word),
		.total_length (total_length),
		.hash_seed    (hash_seed_q),
		.q_full       (q_full),
		.push         (push)
	);

	mh2_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_hash  (q_hash)
	);

	mh2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_hash     (q_hash),
		.pop        (pop),
		.divisor    (divisor),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.bucket     (bucket)
	);

endmodule
`default_nettype wire
